[rtl/core/c2p_pkg.sv]
package c2p_pkg;

    // Field widths
    localparam int COORD_W     = 16;
    localparam int ANGLE_FRAC  = 13;
    localparam int ANGLE_W     = ANGLE_FRAC + 3;
    localparam int SQ_W        = 2 * COORD_W;

    // CORDIC datapath: Q60 angles, operands normalized below 2^59
    localparam int CORDIC_STEPS = 60;
    localparam int WORK_FRAC    = 60;
    localparam int WORK_W       = 64;
    localparam int NORM_TOP     = 58;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    // Stream word widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((COORD_W + ANGLE_W + 7) / 8) * 8;

    typedef logic signed [WORK_W-1:0] work_t;

    // Quadrant information carried alongside the rotation
    typedef struct packed {
        logic x_zero;
        logic y_pos;
    } side_t;

    // Payload handed from cell to cell
    typedef struct packed {
        side_t             side;
        logic [SQ_W-1:0]   sq_rem;
        logic [SQ_W-1:0]   sq_root;
        work_t             xs;
        work_t             ys;
        work_t             z;
    } stage_t;

    // pi in Q60 (pi/4 in Q62) from Machin's formula, evaluated at elaboration
    function automatic logic [63:0] machin_q62();
        logic [63:0] p;
        logic [63:0] t;
        logic [63:0] s5;
        logic [63:0] s239;
        logic        add_term;
        int unsigned k;
        s5 = '0;
        p = 64'h4000_0000_0000_0000 / 5;
        k = 1;
        add_term = 1'b1;
        for (int j = 0; j < 40; j++)
        begin
            if (p != '0)
            begin
                t = p / 64'(k);
                s5 = add_term ? s5 + t : s5 - t;
                add_term = !add_term;
                p = p / 25;
                k = k + 2;
            end
        end
        s239 = '0;
        p = 64'h4000_0000_0000_0000 / 239;
        k = 1;
        add_term = 1'b1;
        for (int j = 0; j < 20; j++)
        begin
            if (p != '0)
            begin
                t = p / 64'(k);
                s239 = add_term ? s239 + t : s239 - t;
                add_term = !add_term;
                p = p / 57121;
                k = k + 2;
            end
        end
        return 64'(4 * s5) - s239;
    endfunction

    localparam logic [63:0] PI_Q60      = machin_q62();
    localparam logic [63:0] HALF_PI_Q60 = (PI_Q60 + 64'd1) >> 1;

    // atan(2^-i) in Q60, from its power series in Q62
    function automatic logic [63:0] atan_q60(input int i);
        logic [63:0] sum;
        logic [63:0] t;
        logic        add_term;
        sum = '0;
        add_term = 1'b1;
        if (i == 0)
        begin
            sum = PI_Q60;
        end
        else
        begin
            for (int k = 1; k < 64; k = k + 2)
            begin
                if (i * k <= 62)
                begin
                    t = (64'd1 << (62 - i * k)) / 64'(k);
                    sum = add_term ? sum + t : sum - t;
                    add_term = !add_term;
                end
            end
        end
        return (sum + 64'd2) >> 2;
    endfunction

    // Trial bit of the square root for cell i; zero once the root is complete
    function automatic logic [SQ_W-1:0] sqrt_bit(input int i);
        logic [SQ_W-1:0] b;
        b = '0;
        if (i < COORD_W)
        begin
            b = SQ_W'(1) << (2 * (COORD_W - 1 - i));
        end
        return b;
    endfunction

endpackage

[rtl/core/c2p_front.sv]
module c2p_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [c2p_pkg::COORD_W-1:0]      x_coord,
    input  logic signed [c2p_pkg::COORD_W-1:0]      y_coord,
    output logic                                    out_valid,
    output c2p_pkg::stage_t                         out_data
);
    import c2p_pkg::*;

    logic                       valid_reg;
    stage_t                     data_reg;
    stage_t                     data_next;

    logic signed [COORD_W:0]    x_ext;
    logic signed [COORD_W:0]    y_ext;
    logic signed [COORD_W:0]    xc;
    logic signed [COORD_W:0]    yc;
    logic signed [COORD_W:0]    ayc;
    logic signed [COORD_W:0]    ay_abs;
    logic        [COORD_W:0]    m;
    logic        [COORD_W-1:0]  ax;
    logic        [COORD_W-1:0]  ay;
    logic        [STEP_W-1:0]   shift;

    // Fold into the right half plane, normalize, square for the root
    always_comb
    begin
        x_ext = {x_coord[COORD_W-1], x_coord};
        y_ext = {y_coord[COORD_W-1], y_coord};
        xc = x_coord[COORD_W-1] ? -x_ext : x_ext;
        yc = x_coord[COORD_W-1] ? -y_ext : y_ext;
        ayc = yc[COORD_W] ? -yc : yc;
        ay_abs = y_coord[COORD_W-1] ? -y_ext : y_ext;
        m = (xc > ayc) ? xc : ayc;
        ax = xc[COORD_W-1:0];
        ay = ay_abs[COORD_W-1:0];

        // shift that puts the leading one of m at bit NORM_TOP
        shift = STEP_W'(NORM_TOP);
        for (int b = 0; b <= COORD_W; b++)
        begin
            if (m[b])
            begin
                shift = STEP_W'(NORM_TOP - b);
            end
        end

        data_next.side.x_zero = (x_coord == '0);
        data_next.side.y_pos = !y_coord[COORD_W-1] && (y_coord != '0);
        data_next.sq_rem = SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);
        data_next.sq_root = '0;
        data_next.xs = WORK_W'(xc) <<< shift;
        data_next.ys = WORK_W'(yc) <<< shift;
        if (!x_coord[COORD_W-1])
        begin
            data_next.z = '0;
        end
        else if (y_coord[COORD_W-1])
        begin
            data_next.z = -work_t'(PI_Q60);
        end
        else
        begin
            data_next.z = work_t'(PI_Q60);
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

[rtl/core/c2p_cell.sv]
module c2p_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [c2p_pkg::STEP_W-1:0]      step,
    input  c2p_pkg::work_t                  atan_step,
    input  logic [c2p_pkg::SQ_W-1:0]        root_bit,
    input  logic                            in_valid,
    input  c2p_pkg::stage_t                 in_data,
    output logic                            out_valid,
    output c2p_pkg::stage_t                 out_data
);
    import c2p_pkg::*;

    logic               valid_reg;
    stage_t             data_reg;
    stage_t             data_next;
    work_t              dx;
    work_t              dy;
    logic [SQ_W-1:0]    trial;

    // One vectoring rotation and one bit of the square root
    always_comb
    begin
        data_next = in_data;
        dx = in_data.ys >>> step;
        dy = in_data.xs >>> step;
        if (!in_data.ys[WORK_W-1])
        begin
            data_next.xs = in_data.xs + dx;
            data_next.ys = in_data.ys - dy;
            data_next.z = in_data.z + atan_step;
        end
        else
        begin
            data_next.xs = in_data.xs - dx;
            data_next.ys = in_data.ys + dy;
            data_next.z = in_data.z - atan_step;
        end

        // restoring root step; passes through once the root is done
        trial = in_data.sq_root + root_bit;
        if (root_bit != '0)
        begin
            if (in_data.sq_rem >= trial)
            begin
                data_next.sq_rem = in_data.sq_rem - trial;
                data_next.sq_root = (in_data.sq_root >> 1) + root_bit;
            end
            else
            begin
                data_next.sq_root = in_data.sq_root >> 1;
            end
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

[rtl/core/cartesian_to_polar.sv]
// Path: an input transfer passes one front stage, one cell per CORDIC rotation
// and one output register before it reaches m_tvalid.
// Throughput: one point per cycle while the chain advances; the chain holds 60
// rotation cells, and a two-entry output buffer stalls it only when full.
// Reset clears all valid flags at once; no clearing pass, no stored state.
module cartesian_to_polar (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [c2p_pkg::IN_TDATA_W-1:0]          s_tdata,  // x_coord, y_coord
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [c2p_pkg::OUT_TDATA_W-1:0]         m_tdata   // magnitude, angle
);
    import c2p_pkg::*;

    logic [CORDIC_STEPS:0]      stage_valid;
    stage_t                     stage_data [CORDIC_STEPS+1];
    logic                       pipe_en;
    logic                       last_valid;

    stage_t                     last;
    work_t                      angle_q60;
    work_t                      angle_rnd;
    logic [SQ_W-1:0]            mag_full;
    logic [COORD_W-1:0]         mag_res;
    logic [ANGLE_W-1:0]         angle_res;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [COORD_W-1:0]         out_mag_reg;
    logic [ANGLE_W-1:0]         out_angle_reg;
    logic                       skid_valid_reg;
    logic                       skid_valid_next;
    logic [COORD_W-1:0]         skid_mag_reg;
    logic [ANGLE_W-1:0]         skid_angle_reg;
    logic                       out_load;

    localparam work_t ROUND_ADD = work_t'(1) <<< (WORK_FRAC - 1 - ANGLE_FRAC);

    // Chain advances unless the output buffer is full
    assign pipe_en = !skid_valid_reg;
    assign s_tready = pipe_en;

    c2p_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .x_coord   (s_tdata[COORD_W-1:0]),
        .y_coord   (s_tdata[2*COORD_W-1:COORD_W]),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0])
    );

    // Rotation cells
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        localparam logic [WORK_W-1:0] ATAN_I = atan_q60(i);
        localparam logic [SQ_W-1:0]   BIT_I  = sqrt_bit(i);

        c2p_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .step      (STEP_W'(i)),
            .atan_step (work_t'(ATAN_I)),
            .root_bit  (BIT_I),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    // Quadrant fix-up and rounding of both results
    always_comb
    begin
        last = stage_data[CORDIC_STEPS];
        if (!last.side.x_zero)
        begin
            angle_q60 = last.z;
        end
        else if (last.side.y_pos)
        begin
            angle_q60 = work_t'(HALF_PI_Q60);
        end
        else
        begin
            angle_q60 = -work_t'(HALF_PI_Q60);
        end
        angle_rnd = (angle_q60 + ROUND_ADD) >>> (WORK_FRAC - ANGLE_FRAC);
        angle_res = angle_rnd[ANGLE_W-1:0];
        mag_full = (last.sq_rem > last.sq_root) ? last.sq_root + SQ_W'(1) : last.sq_root;
        mag_res = mag_full[COORD_W-1:0];
    end

    assign last_valid = stage_valid[CORDIC_STEPS] && pipe_en;

    // Output register with skid entry
    always_comb
    begin
        out_load = !out_valid_reg || m_tready;
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_load)
        begin
            out_valid_next = skid_valid_reg || last_valid;
            skid_valid_next = 1'b0;
        end
        else if (last_valid)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_mag_reg <= skid_mag_reg;
                out_angle_reg <= skid_angle_reg;
            end
            else
            begin
                out_mag_reg <= mag_res;
                out_angle_reg <= angle_res;
            end
        end
        else if (last_valid)
        begin
            skid_mag_reg <= mag_res;
            skid_angle_reg <= angle_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = OUT_TDATA_W'({out_angle_reg, out_mag_reg});

    // Skid entry only ever holds data behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // A result leaving the chain during an output stall lands in the skid entry
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (last_valid && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result lost during output stall");

    // Skid entry fills only from a stalled output
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid entry filled without a stall");

    // A frozen chain keeps its final stage
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(stage_valid[CORDIC_STEPS]))
        else $error("chain moved while stalled");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import c2p_pkg::*;

    // Expected polar result of one point
    typedef struct {
        logic [COORD_W-1:0]        mag;
        logic signed [ANGLE_W-1:0] ang;
    } polar_t;

    // One row of the directed table; typed rows carry their own answer
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        bit                        typed;
        logic [COORD_W-1:0]        mag;
        logic signed [ANGLE_W-1:0] ang;
    } probe_t;

    localparam int NUM_PROBES   = 22;
    localparam int NUM_RANDOM   = 900;
    localparam int DRAIN_CYCLES = 80;

    // Angles in steps of 2^-13 rad: pi, pi/2
    localparam logic signed [ANGLE_W-1:0] ANG_PI   = 16'sd25736;
    localparam logic signed [ANGLE_W-1:0] ANG_HALF = 16'sd12868;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;     // x_coord, y_coord
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // magnitude, angle

    longint unsigned arctan_q60 [CORDIC_STEPS];
    longint unsigned pi_q60;

    polar_t pending_polar [$];
    int     mismatches   = 0;
    int     points_sent  = 0;
    int     results_seen = 0;

    probe_t probes [NUM_PROBES] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'd0,     -ANG_HALF},
        '{16'sd32767,  16'sd0,      1'b1, 16'd32767, 16'sd0},
        '{-16'sd32768, 16'sd0,      1'b1, 16'd32768, ANG_PI},
        '{16'sd0,      16'sd32767,  1'b1, 16'd32767, ANG_HALF},
        '{16'sd0,      -16'sd32768, 1'b1, 16'd32768, -ANG_HALF},
        '{16'sd1,      16'sd0,      1'b1, 16'd1,     16'sd0},
        '{-16'sd1,     16'sd0,      1'b1, 16'd1,     ANG_PI},
        '{16'sd0,      16'sd1,      1'b1, 16'd1,     ANG_HALF},
        '{16'sd0,      -16'sd1,     1'b1, 16'd1,     -ANG_HALF},
        '{-16'sd32768, -16'sd32768, 1'b0, 16'd0,     16'sd0},
        '{16'sd32767,  16'sd32767,  1'b0, 16'd0,     16'sd0},
        '{-16'sd32768, 16'sd32767,  1'b0, 16'd0,     16'sd0},
        '{16'sd32767,  -16'sd32768, 1'b0, 16'd0,     16'sd0},
        '{-16'sd32768, -16'sd1,     1'b0, 16'd0,     16'sd0},
        '{-16'sd32768, 16'sd1,      1'b0, 16'd0,     16'sd0},
        '{-16'sd1,     -16'sd32768, 1'b0, 16'd0,     16'sd0},
        '{16'sd1,      16'sd1,      1'b0, 16'd0,     16'sd0},
        '{-16'sd1,     16'sd1,      1'b0, 16'd0,     16'sd0},
        '{-16'sd1,     -16'sd1,     1'b0, 16'd0,     16'sd0},
        '{16'sd1,      -16'sd1,     1'b0, 16'd0,     16'sd0},
        '{16'sd3,      16'sd4,      1'b0, 16'd0,     16'sd0},
        '{-16'sd12,    -16'sd5,     1'b0, 16'd0,     16'sd0}
    };

    cartesian_to_polar dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // atan(1/d) in Q62, alternating power series
    function automatic longint unsigned atan_recip_q62(input longint unsigned d);
        longint unsigned p;
        longint unsigned acc;
        longint unsigned k;
        bit              plus;
        p = (64'd1 << 62) / d;
        acc = 0;
        k = 1;
        plus = 1'b1;
        while (p != 0)
        begin
            acc = plus ? acc + p / k : acc - p / k;
            plus = !plus;
            p = p / (d * d);
            k = k + 2;
        end
        return acc;
    endfunction

    // pi by Machin's formula, then atan(2^-i) in Q60 for each rotation
    function automatic void build_arctan_table();
        longint unsigned acc;
        bit              plus;
        pi_q60 = 4 * atan_recip_q62(5) - atan_recip_q62(239);
        arctan_q60[0] = (pi_q60 + 2) >> 2;
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            acc = 0;
            plus = 1'b1;
            for (int k = 1; i * k <= 62; k += 2)
            begin
                acc = plus ? acc + (64'd1 << (62 - i * k)) / k
                           : acc - (64'd1 << (62 - i * k)) / k;
                plus = !plus;
            end
            arctan_q60[i] = (acc + 2) >> 2;
        end
    endfunction

    // Square root rounded to nearest; ties cannot happen for integers
    function automatic longint unsigned rounded_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 17; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        if (n - root * root > root)
            root = root + 1;
        return root;
    endfunction

    // Magnitude and atan2 angle of one point
    function automatic polar_t polar_of(input logic signed [COORD_W-1:0] xc,
                                        input logic signed [COORD_W-1:0] yc);
        longint sx;
        longint sy;
        longint ax;
        longint ay;
        longint peak;
        longint xs;
        longint ys;
        longint dx;
        longint dy;
        longint z;
        longint quad;
        longint theta;
        longint stepped;
        int     shift;
        polar_t res;
        sx = xc;
        sy = yc;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        res.mag = COORD_W'(rounded_root(ax * ax + ay * ay));
        if (sx == 0)
        begin
            theta = longint'((pi_q60 + 1) >> 1);
            if (sy <= 0)
                theta = -theta;
        end
        else
        begin
            // fold the left half plane onto the right one
            quad = 0;
            if (sx < 0)
            begin
                quad = (sy < 0) ? -longint'(pi_q60) : longint'(pi_q60);
                sx = -sx;
                sy = -sy;
            end
            ay = (sy < 0) ? -sy : sy;
            peak = (sx > ay) ? sx : ay;
            shift = 0;
            while (peak < (longint'(1) <<< NORM_TOP))
            begin
                peak = peak <<< 1;
                shift++;
            end
            xs = sx <<< shift;
            ys = sy <<< shift;
            z = 0;
            // vectoring rotations drive y toward zero
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = ys >>> i;
                dy = xs >>> i;
                if (ys >= 0)
                begin
                    xs = xs + dx;
                    ys = ys - dy;
                    z = z + longint'(arctan_q60[i]);
                end
                else
                begin
                    xs = xs - dx;
                    ys = ys + dy;
                    z = z - longint'(arctan_q60[i]);
                end
            end
            theta = quad + z;
        end
        // round half up to 2^-13 rad
        stepped = (theta + (longint'(1) <<< (WORK_FRAC - 1 - ANGLE_FRAC)))
                  >>> (WORK_FRAC - ANGLE_FRAC);
        res.ang = stepped[ANGLE_W-1:0];
        return res;
    endfunction

    // Random point drawn from one of several families
    function automatic logic [2*COORD_W-1:0] draw_point();
        logic signed [COORD_W-1:0] xr;
        logic signed [COORD_W-1:0] yr;
        logic signed [COORD_W-1:0] corner [6];
        int                        family;
        corner = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
        family = $urandom_range(0, 9);
        xr = COORD_W'($urandom);
        yr = COORD_W'($urandom);
        case (family)
            5:
            begin
                xr = COORD_W'($urandom_range(0, 8)) - 16'sd4;
                yr = COORD_W'($urandom_range(0, 8)) - 16'sd4;
            end
            6:
            begin
                if ($urandom_range(0, 1) == 0)
                    xr = '0;
                else
                    yr = '0;
            end
            7:
            begin
                yr = ($urandom_range(0, 1) == 0) ? xr : -xr;
                yr = yr + (COORD_W'($urandom_range(0, 6)) - 16'sd3);
            end
            8:
            begin
                xr = corner[$urandom_range(0, 5)];
                yr = corner[$urandom_range(0, 5)];
            end
            9:
            begin
                xr[COORD_W-2:COORD_W-5] = {4{xr[COORD_W-1]}} ^ 4'b0000;
                xr[COORD_W-2] = ~xr[COORD_W-1];
                yr[COORD_W-2] = ~yr[COORD_W-1];
            end
            default:
            begin
            end
        endcase
        return {yr, xr};
    endfunction

    // Offer one point, idling first unless feeding steadily, and record its expected result on transfer
    bit feed_steady = 1'b0;

    task automatic offer_point(input logic signed [COORD_W-1:0] xc,
                               input logic signed [COORD_W-1:0] yc,
                               input bit typed, input polar_t want);
        int gap;
        if (points_sent % 40 == 0)
            feed_steady = ($urandom_range(0, 2) == 0);
        gap = feed_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({yc, xc});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_polar.push_back(typed ? want : polar_of(xc, yc));
        points_sent++;
    endtask

    // Result side: random stalls, with steady stretches
    initial
    begin
        int  stall;
        int  taken;
        bit  drain_steady;
        taken = 0;
        drain_steady = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 40 == 0)
                drain_steady = ($urandom_range(0, 2) == 0);
            stall = drain_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    // Compare each result transfer with the oldest pending point
    always @(posedge clk)
    begin
        polar_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_polar.size() == 0)
            begin
                $error("result transfer with no pending point: magnitude %0d angle %0d",
                       m_tdata[COORD_W-1:0],
                       $signed(m_tdata[COORD_W+ANGLE_W-1:COORD_W]));
                mismatches++;
            end
            else
            begin
                want = pending_polar.pop_front();
                if (m_tdata[COORD_W-1:0] !== want.mag)
                begin
                    $error("magnitude: expected %0d, got %0d",
                           want.mag, m_tdata[COORD_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[COORD_W+ANGLE_W-1:COORD_W] !== want.ang)
                begin
                    $error("angle: expected %0d, got %0d", want.ang,
                           $signed(m_tdata[COORD_W+ANGLE_W-1:COORD_W]));
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        logic [2*COORD_W-1:0] pt;
        polar_t               unused;
        build_arctan_table();
        unused = '{default: '0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_PROBES; i++)
            offer_point(probes[i].x, probes[i].y, probes[i].typed,
                        '{mag: probes[i].mag, ang: probes[i].ang});

        // random points
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            pt = draw_point();
            offer_point(pt[COORD_W-1:0], pt[2*COORD_W-1:COORD_W], 1'b0, unused);
        end
        s_tvalid <= 1'b0;

        while (pending_polar.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Points sent: %0d (%0d directed, %0d random); results checked: %0d",
                 points_sent, NUM_PROBES, NUM_RANDOM, results_seen);
        $display("Covered axes, all four quadrants, full-scale corners and the origin");
        if (mismatches == 0 && pending_polar.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[cartesian_to_polar.f]
rtl/core/c2p_pkg.sv
rtl/core/c2p_front.sv
rtl/core/c2p_cell.sv
rtl/core/cartesian_to_polar.sv
dv/testbench.sv
